[design/cpt_pkg.sv]
// Shared types, tone constants and helper functions for the call-progress tone cadence block.
package cpt_pkg;

    localparam int TIME_BITS = 32;
    localparam int FREQ_BITS = 15;
    localparam int DUR_BITS  = 12;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [FREQ_BITS-1:0] freq_t;
    typedef logic [DUR_BITS-1:0]  dur_t;
    typedef logic [1:0]           sit_step_t;

    typedef enum logic [2:0] {
        MODE_DIAL    = 3'd0,
        MODE_RING    = 3'd1,
        MODE_BUSY    = 3'd2,
        MODE_REORDER = 3'd3,
        MODE_ERROR   = 3'd4,
        MODE_SILENT  = 3'd5
    } tone_mode_t;

    localparam logic REG_TONE_MODE   = 1'b0;
    localparam logic REG_DUAL_ENABLE = 1'b1;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam sit_step_t SIT_STEP_F1 = 2'd0;
    localparam sit_step_t SIT_STEP_F2 = 2'd1;
    localparam sit_step_t SIT_STEP_F3 = 2'd2;
    localparam sit_step_t SIT_IDLE    = 2'd3;

    localparam freq_t FREQ_OFF = 15'd0;
    localparam freq_t DIAL_LO  = 15'd3500;
    localparam freq_t DIAL_HI  = 15'd4400;
    localparam freq_t RING_LO  = 15'd4400;
    localparam freq_t RING_HI  = 15'd4800;
    localparam freq_t BUSY_LO  = 15'd4800;
    localparam freq_t BUSY_HI  = 15'd6200;
    localparam freq_t SIT_F1   = 15'd9138;
    localparam freq_t SIT_F2   = 15'd14285;
    localparam freq_t SIT_F3   = 15'd17767;

    localparam dur_t RING_ON   = 12'd2000;
    localparam dur_t RING_OFF  = 12'd4000;
    localparam dur_t BUSY_ON   = 12'd500;
    localparam dur_t BUSY_OFF  = 12'd500;
    localparam dur_t REORD_ON  = 12'd250;
    localparam dur_t REORD_OFF = 12'd250;

    localparam int SIT_T1  = 380;
    localparam int SIT_GAP = 30;
    localparam int SIT_T2  = 276;
    localparam int SIT_T3  = 380;
    localparam int SIT_SIL = 2000;

    localparam dur_t SIT_B1    = DUR_BITS'(SIT_T1);
    localparam dur_t SIT_B2    = DUR_BITS'(SIT_T1 + SIT_GAP);
    localparam dur_t SIT_B3    = DUR_BITS'(SIT_T1 + SIT_GAP + SIT_T2);
    localparam dur_t SIT_B4    = DUR_BITS'(SIT_T1 + 2 * SIT_GAP + SIT_T2);
    localparam dur_t SIT_B5    = DUR_BITS'(SIT_T1 + 2 * SIT_GAP + SIT_T2 + SIT_T3);
    localparam dur_t SIT_TOTAL = DUR_BITS'(SIT_T1 + 2 * SIT_GAP + SIT_T2 + SIT_T3 + SIT_SIL);

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [14:0] freq_a_dhz;
        logic [14:0] freq_b_dhz;
        logic        tone_on;
        logic        changed;
    } out_item_t;

    typedef struct packed {
        time_t     last_change_ms;
        logic      tone_active;
        sit_step_t sit_step;
        freq_t     gen_a_freq;
        freq_t     gen_b_freq;
    } cad_state_t;

    function automatic freq_t pair_a(freq_t fa, freq_t fb, logic dual);
        logic [FREQ_BITS:0] sum;
        sum = {1'b0, fa} + {1'b0, fb};
        return dual ? fa : sum[FREQ_BITS:1];
    endfunction

    function automatic freq_t pair_b(freq_t fb, logic dual);
        return dual ? fb : FREQ_OFF;
    endfunction

    function automatic time_t dur_to_time(dur_t d);
        return TIME_BITS'(d);
    endfunction

endpackage

[design/call_progress_tone_cadence.sv]
// Top level of the call-progress tone cadence sequencer: item registers, state and configuration.
// Takes one item (tick or restart) per clock cycle while the output side is ready and delivers
// one result item for each: the item is held in the input register, then makes one pass through
// the elapsed-time subtract, the cadence compares and the frequency select into the result
// register, which also updates the cadence state so the next item sees it at once.
// The output register lets a new item enter while a finished result waits to be taken.
// tone_mode and dual_enable are written through cfg_we/cfg_index/cfg_data; the user must do so
// only while no item is in flight; the block does not enforce it. No clearing pass after reset.
module call_progress_tone_cadence (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpt_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cpt_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [2:0]          cfg_data
);
    import cpt_pkg::*;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    cad_state_t state_reg;
    cad_state_t state_next;
    out_item_t  result_next;
    tone_mode_t mode_reg;
    logic       dual_reg;
    logic       advance;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    cpt_step u_step (
        .st      (state_reg),
        .item    (in_item_reg),
        .mode    (mode_reg),
        .dual    (dual_reg),
        .st_next (state_next),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.last_change_ms <= '0;
            state_reg.tone_active    <= 1'b0;
            state_reg.sit_step       <= SIT_IDLE;
            state_reg.gen_a_freq     <= FREQ_OFF;
            state_reg.gen_b_freq     <= FREQ_OFF;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DIAL;
            dual_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TONE_MODE:   mode_reg <= tone_mode_t'(cfg_data);
                REG_DUAL_ENABLE: dual_reg <= cfg_data[0];
                default:         mode_reg <= mode_reg;
            endcase
        end
    end

endmodule

[design/cpt_step.sv]
// Next-state and result logic for one tick or restart item.
module cpt_step (
    input  cpt_pkg::cad_state_t  st,
    input  cpt_pkg::in_item_t    item,
    input  cpt_pkg::tone_mode_t  mode,
    input  logic                 dual,
    output cpt_pkg::cad_state_t  st_next,
    output cpt_pkg::out_item_t   result
);
    import cpt_pkg::*;

    time_t     now_t;
    time_t     el;
    time_t     el_sit;
    freq_t     cad_lo;
    freq_t     cad_hi;
    dur_t      cad_on;
    dur_t      cad_off;
    sit_step_t sit_cur;

    assign now_t = TIME_BITS'(item.now_ms);
    assign el    = now_t - st.last_change_ms;

    always_comb
    begin
        unique case (mode)
            MODE_RING:
            begin
                cad_lo  = RING_LO;
                cad_hi  = RING_HI;
                cad_on  = RING_ON;
                cad_off = RING_OFF;
            end
            MODE_BUSY:
            begin
                cad_lo  = BUSY_LO;
                cad_hi  = BUSY_HI;
                cad_on  = BUSY_ON;
                cad_off = BUSY_OFF;
            end
            default:
            begin
                cad_lo  = BUSY_LO;
                cad_hi  = BUSY_HI;
                cad_on  = REORD_ON;
                cad_off = REORD_OFF;
            end
        endcase
    end

    always_comb
    begin
        st_next = st;
        sit_cur = st.sit_step;
        el_sit  = el;
        if (item.cmd == CMD_RESTART)
        begin
            st_next.last_change_ms = now_t;
            st_next.tone_active    = 1'b0;
            st_next.sit_step       = SIT_IDLE;
            st_next.gen_a_freq     = FREQ_OFF;
            st_next.gen_b_freq     = FREQ_OFF;
        end
        else
        begin
            unique case (mode)
                MODE_DIAL:
                begin
                    st_next.gen_a_freq  = pair_a(DIAL_LO, DIAL_HI, dual);
                    st_next.gen_b_freq  = pair_b(DIAL_HI, dual);
                    st_next.tone_active = 1'b1;
                end
                MODE_RING, MODE_BUSY, MODE_REORDER:
                begin
                    if (!st.tone_active && el >= dur_to_time(cad_off))
                    begin
                        st_next.gen_a_freq     = pair_a(cad_lo, cad_hi, dual);
                        st_next.gen_b_freq     = pair_b(cad_hi, dual);
                        st_next.tone_active    = 1'b1;
                        st_next.last_change_ms = now_t;
                    end
                    else if (st.tone_active && el >= dur_to_time(cad_on))
                    begin
                        st_next.gen_a_freq     = FREQ_OFF;
                        st_next.gen_b_freq     = FREQ_OFF;
                        st_next.tone_active    = 1'b0;
                        st_next.last_change_ms = now_t;
                    end
                end
                MODE_ERROR:
                begin
                    if (el >= dur_to_time(SIT_TOTAL))
                    begin
                        sit_cur                = SIT_IDLE;
                        st_next.last_change_ms = now_t;
                        el_sit                 = '0;
                    end
                    st_next.sit_step = sit_cur;
                    priority if (el_sit < dur_to_time(SIT_B1))
                    begin
                        if (sit_cur != SIT_STEP_F1)
                        begin
                            st_next.gen_a_freq  = SIT_F1;
                            st_next.gen_b_freq  = FREQ_OFF;
                            st_next.sit_step    = SIT_STEP_F1;
                            st_next.tone_active = 1'b1;
                        end
                    end
                    else if ((el_sit >= dur_to_time(SIT_B2)) && (el_sit < dur_to_time(SIT_B3)))
                    begin
                        if (sit_cur != SIT_STEP_F2)
                        begin
                            st_next.gen_a_freq  = SIT_F2;
                            st_next.gen_b_freq  = FREQ_OFF;
                            st_next.sit_step    = SIT_STEP_F2;
                            st_next.tone_active = 1'b1;
                        end
                    end
                    else if ((el_sit >= dur_to_time(SIT_B4)) && (el_sit < dur_to_time(SIT_B5)))
                    begin
                        if (sit_cur != SIT_STEP_F3)
                        begin
                            st_next.gen_a_freq  = SIT_F3;
                            st_next.gen_b_freq  = FREQ_OFF;
                            st_next.sit_step    = SIT_STEP_F3;
                            st_next.tone_active = 1'b1;
                        end
                    end
                    else
                    begin
                        if (st.tone_active)
                        begin
                            st_next.gen_a_freq  = FREQ_OFF;
                            st_next.gen_b_freq  = FREQ_OFF;
                            st_next.tone_active = 1'b0;
                        end
                    end
                end
                MODE_SILENT:
                begin
                    st_next.gen_a_freq  = FREQ_OFF;
                    st_next.gen_b_freq  = FREQ_OFF;
                    st_next.tone_active = 1'b0;
                end
                default:
                begin
                    st_next = st;
                end
            endcase
        end
    end

    always_comb
    begin
        result.freq_a_dhz = st_next.gen_a_freq;
        result.freq_b_dhz = st_next.gen_b_freq;
        result.tone_on    = st_next.tone_active;
        result.changed    = (st_next.gen_a_freq != st.gen_a_freq)
                         || (st_next.gen_b_freq != st.gen_b_freq);
    end

endmodule
